[rtl/tbsp_pkg.sv]
package tbsp_pkg;
	typedef enum logic [2:0] {
		FN_CREATE = 3'd0,
		FN_START  = 3'd1,
		FN_STOP   = 3'd2,
		FN_DELETE = 3'd3,
		FN_SETIV  = 3'd4,
		FN_TICK   = 3'd5,
		FN_QUERY  = 3'd6,
		FN_NOP    = 3'd7
	} func_t;

	localparam logic [1:0] EV_DONE     = 2'd0;
	localparam logic [1:0] EV_EXPIRED  = 2'd1;
	localparam logic [1:0] EV_TICK_END = 2'd2;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [4:0]  slot;
		logic [31:0] interval;
		logic        periodic;
		logic [31:0] elapsed;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [1:0]  status;
		logic [4:0]  slot_out;
		logic        is_active;
		logic [31:0] remaining_out;
		logic        last;
	} res_t;
endpackage

[rtl/tbsp_cmd_fifo.sv]
module tbsp_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tbsp_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output tbsp_pkg::cmd_t rdata,
	output logic          empty
);
	import tbsp_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end
endmodule

[rtl/tbsp_res_fifo.sv]
module tbsp_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tbsp_pkg::res_t wdata,
	output logic          full,
	input  logic          rd,
	output tbsp_pkg::res_t rdata,
	output logic          empty
);
	import tbsp_pkg::*;

	res_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end
endmodule

[rtl/tbsp_engine.sv]
module tbsp_engine #(
	parameter int NUM_TIMERS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tbsp_pkg::cmd_t cmd,
	output logic           cmd_take,
	output logic           res_valid,
	output tbsp_pkg::res_t res,
	input  logic           res_full
);
	import tbsp_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_TICK, S_END} state_t;

	logic [31:0]   reload_q [NUM_TIMERS];
	logic [31:0]   count_q  [NUM_TIMERS];
	logic          auto_q   [NUM_TIMERS];
	logic [IW-1:0] stack_q  [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] run_q, alloc_q, stk_init_q;
	logic [CW-1:0] fcnt_q;

	state_t        st_q;
	cmd_t          c_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   rl_rd_q, cnt_rd_q;
	logic          auto_rd_q;
	logic [IW-1:0] pop_rd_q;

	logic          slot_ok;
	logic [IW-1:0] sidx, top_idx, top_val, cmd_idx, rd_idx;
	logic [31:0]   rl_wd, cnt_wd;
	logic          rl_we, cnt_we, auto_we, stk_we;
	logic [IW-1:0] rl_wa, cnt_wa, auto_wa, stk_wa, stk_wd;
	logic          expire, emit_ok;

	assign sidx    = IW'({1'b0, c_q.slot});
	assign cmd_idx = IW'({1'b0, cmd.slot});
	assign slot_ok = ({2'b0, c_q.slot} < 7'(NUM_TIMERS)) && alloc_q[sidx];
	assign top_idx = IW'(fcnt_q - CW'(1));
	assign top_val = stk_init_q[top_idx] ? stack_q[top_idx] : IW'(NUM_TIMERS - 1) - top_idx;
	assign expire  = run_q[idx_q] && !(cnt_rd_q > c_q.elapsed);
	assign cmd_take = (st_q == S_IDLE) && cmd_valid;
	// a stalled tick slot re-reads its own entry
	assign rd_idx  = (st_q == S_TICK) ?
		((expire && !emit_ok) ? idx_q : IW'(idx_q + IW'(1))) :
		(cmd_take ? ((cmd.func == FN_TICK) ? IW'(0) : cmd_idx) : sidx);

	always_ff @(posedge clk) begin
		if (rl_we) reload_q[rl_wa] <= rl_wd;
		if (cnt_we) count_q[cnt_wa] <= cnt_wd;
		if (auto_we) auto_q[auto_wa] <= c_q.periodic;
		if (stk_we) stack_q[stk_wa] <= stk_wd;
		rl_rd_q   <= reload_q[rd_idx];
		cnt_rd_q  <= count_q[rd_idx];
		auto_rd_q <= auto_q[rd_idx];
		pop_rd_q  <= top_val;
	end

	always_comb begin
		rl_we = 1'b0; cnt_we = 1'b0; auto_we = 1'b0; stk_we = 1'b0;
		rl_wa = sidx; cnt_wa = sidx; auto_wa = pop_rd_q; stk_wa = IW'(fcnt_q);
		rl_wd = c_q.interval; cnt_wd = '0; stk_wd = sidx;
		res_valid = 1'b0; emit_ok = !res_full;
		res = '{EV_DONE, ST_OK, 5'd0, 1'b0, 32'd0, 1'b1};
		case (st_q)
			S_RD: begin
				res_valid = 1'b1;
				case (c_q.func)
					FN_CREATE: begin
						if (fcnt_q == '0) res.status = ST_NO_FREE;
						else begin
							res.slot_out = 5'(pop_rd_q);
							rl_we = emit_ok; rl_wa = pop_rd_q;
							cnt_we = emit_ok; cnt_wa = pop_rd_q;
							auto_we = emit_ok;
						end
					end
					FN_NOP: ;
					default: begin
						res.slot_out = c_q.slot;
						if (!slot_ok) res.status = ST_NOT_ALLOC;
						else case (c_q.func)
							FN_START: begin
								cnt_we = emit_ok; cnt_wd = rl_rd_q;
							end
							FN_STOP: cnt_we = emit_ok;
							FN_DELETE: begin
								cnt_we = emit_ok;
								stk_we = emit_ok && (fcnt_q < CW'(NUM_TIMERS));
							end
							FN_SETIV: rl_we = emit_ok;
							FN_QUERY: begin
								res.is_active = run_q[sidx];
								res.remaining_out = cnt_rd_q;
							end
							default: ;
						endcase
					end
				endcase
			end
			S_TICK: begin
				cnt_wa = idx_q;
				if (run_q[idx_q]) begin
					if (!expire) begin
						cnt_we = 1'b1; cnt_wd = cnt_rd_q - c_q.elapsed;
					end else begin
						res_valid = 1'b1;
						res = '{EV_EXPIRED, ST_OK, 5'(idx_q), 1'b0, 32'd0, 1'b0};
						cnt_we = emit_ok;
						cnt_wd = auto_rd_q ? rl_rd_q : 32'd0;
						stk_wa = IW'(fcnt_q); stk_wd = idx_q;
						stk_we = emit_ok && !auto_rd_q && (fcnt_q < CW'(NUM_TIMERS));
					end
				end
			end
			S_END: begin
				res_valid = 1'b1;
				res.event_res = EV_TICK_END;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			run_q <= '0; alloc_q <= '0; stk_init_q <= '0;
			fcnt_q <= CW'(NUM_TIMERS);
			idx_q <= '0;
		end else begin
			if (stk_we) stk_init_q[stk_wa] <= 1'b1;
			case (st_q)
				S_IDLE: if (cmd_valid) begin
					c_q <= cmd; idx_q <= '0;
					st_q <= (cmd.func == FN_TICK) ? S_TICK : S_RD;
				end
				S_RD: if (emit_ok) begin
					st_q <= S_IDLE;
					case (c_q.func)
						FN_CREATE: if (fcnt_q != '0) begin
							fcnt_q <= fcnt_q - CW'(1);
							alloc_q[pop_rd_q] <= 1'b1;
							run_q[pop_rd_q] <= 1'b0;
						end
						FN_NOP: ;
						default: if (slot_ok) case (c_q.func)
							FN_START: run_q[sidx] <= 1'b1;
							FN_STOP: run_q[sidx] <= 1'b0;
							FN_DELETE: begin
								run_q[sidx] <= 1'b0; alloc_q[sidx] <= 1'b0;
								if (fcnt_q < CW'(NUM_TIMERS)) fcnt_q <= fcnt_q + CW'(1);
							end
							default: ;
						endcase
					endcase
				end
				S_TICK: if (!(expire && !emit_ok)) begin
					if (expire && !auto_rd_q) begin
						run_q[idx_q] <= 1'b0; alloc_q[idx_q] <= 1'b0;
						if (fcnt_q < CW'(NUM_TIMERS)) fcnt_q <= fcnt_q + CW'(1);
					end
					if (idx_q == IW'(NUM_TIMERS - 1)) st_q <= S_END;
					else idx_q <= idx_q + IW'(1);
				end
				S_END: if (emit_ok) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/timer_bank_with_slot_pool_unit.sv]
// channel | handshake        | fields
// input   | push / full      | func slot interval periodic elapsed
// result  | pop / empty      | event_res status slot_out is_active remaining_out last
// A command other than tick is taken in idle, its slot is read from the tables and
// its result is written, and the engine returns to idle; a tick walks the slots in
// order from slot 0 up to the last, then writes its closing item.
// arst_n clears the pool to all free with slot 0 on top. Two-entry queues sit
// on both sides; a full result queue holds the engine while it has a result to write.
module timer_bank_with_slot_pool_unit #(
	parameter int NUM_TIMERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  func,
	input  logic [4:0]  slot,
	input  logic [31:0] interval,
	input  logic        periodic,
	input  logic [31:0] elapsed,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_res,
	output logic [1:0]  status,
	output logic [4:0]  slot_out,
	output logic        is_active,
	output logic [31:0] remaining_out,
	output logic        last
);
	import tbsp_pkg::*;

	cmd_t in_c, q_c;
	res_t e_r, o_r;
	logic q_empty, take, e_v, r_full;

	assign in_c = '{func, slot, interval, periodic, elapsed};

	tbsp_cmd_fifo u_cq (.clk, .arst_n, .wr(push), .wdata(in_c), .full,
		.rd(take), .rdata(q_c), .empty(q_empty));

	tbsp_engine #(.NUM_TIMERS(NUM_TIMERS)) u_eng (.clk, .arst_n,
		.cmd_valid(!q_empty), .cmd(q_c), .cmd_take(take),
		.res_valid(e_v), .res(e_r), .res_full(r_full));

	tbsp_res_fifo u_rq (.clk, .arst_n, .wr(e_v), .wdata(e_r), .full(r_full),
		.rd(pop), .rdata(o_r), .empty);

	assign event_res     = o_r.event_res;
	assign status        = o_r.status;
	assign slot_out      = o_r.slot_out;
	assign is_active     = o_r.is_active;
	assign remaining_out = o_r.remaining_out;
	assign last          = o_r.last;
endmodule

[tb/tb_timer_bank_with_slot_pool_unit.sv]
module tb_timer_bank_with_slot_pool_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import tbsp_pkg::*;

	localparam int NT = 32;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [2:0] func;
	logic [4:0] slot;
	logic [31:0] interval;
	logic periodic;
	logic [31:0] elapsed;
	logic empty;
	logic pop;
	logic [1:0] event_res;
	logic [1:0] status;
	logic [4:0] slot_out;
	logic is_active;
	logic [31:0] remaining_out;
	logic last;

	timer_bank_with_slot_pool_unit #(.NUM_TIMERS(NT)) DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func), .slot(slot),
		.interval(interval), .periodic(periodic), .elapsed(elapsed), .empty(empty),
		.pop(pop), .event_res(event_res), .status(status), .slot_out(slot_out),
		.is_active(is_active), .remaining_out(remaining_out), .last(last)
	);

	logic [31:0] reload_q[NT];
	logic [31:0] count_q[NT];
	bit run_q[NT];
	bit auto_q[NT];
	bit alloc_q[NT];
	logic [4:0] free_stk[NT];
	int free_n;

	res_t expected_q[$];
	int errors = 0;
	int results_seen = 0;
	int expiries_seen = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit idle_on = 1;
	bit hold_pop = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic res_t mk(logic [1:0] ev, logic [1:0] st, logic [4:0] s,
			logic act, logic [31:0] rem, logic lst);
		res_t r;
		r.event_res = ev;
		r.status = st;
		r.slot_out = s;
		r.is_active = act;
		r.remaining_out = rem;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_timers(cmd_t c);
		int i;
		logic [4:0] s;
		s = c.slot;
		case (func_t'(c.func))
			FN_CREATE: begin
				if (free_n == 0) begin
					expected_q.push_back(mk(EV_DONE, ST_NO_FREE, 0, 0, 0, 1));
				end else begin
					free_n--;
					s = free_stk[free_n];
					reload_q[s] = c.interval;
					count_q[s] = 0;
					auto_q[s] = c.periodic;
					run_q[s] = 0;
					alloc_q[s] = 1;
					expected_q.push_back(mk(EV_DONE, ST_OK, s, 0, 0, 1));
				end
			end
			FN_TICK: begin
				for (i = 0; i < NT; i++) begin
					if (!run_q[i]) continue;
					if (count_q[i] > c.elapsed) begin
						count_q[i] -= c.elapsed;
						continue;
					end
					count_q[i] = 0;
					run_q[i] = 0;
					expected_q.push_back(mk(EV_EXPIRED, ST_OK, 5'(i), 0, 0, 0));
					if (auto_q[i]) begin
						count_q[i] = reload_q[i];
						run_q[i] = 1;
					end else begin
						alloc_q[i] = 0;
						free_stk[free_n] = 5'(i);
						free_n++;
					end
				end
				expected_q.push_back(mk(EV_TICK_END, ST_OK, 0, 0, 0, 1));
			end
			FN_NOP: expected_q.push_back(mk(EV_DONE, ST_OK, 0, 0, 0, 1));
			default: begin
				if (!alloc_q[s]) begin
					expected_q.push_back(mk(EV_DONE, ST_NOT_ALLOC, s, 0, 0, 1));
				end else begin
					case (func_t'(c.func))
						FN_START: begin
							count_q[s] = reload_q[s];
							run_q[s] = 1;
						end
						FN_STOP: begin
							run_q[s] = 0;
							count_q[s] = 0;
						end
						FN_DELETE: begin
							run_q[s] = 0;
							count_q[s] = 0;
							alloc_q[s] = 0;
							free_stk[free_n] = s;
							free_n++;
						end
						FN_SETIV: reload_q[s] = c.interval;
						default: ;
					endcase
					if (func_t'(c.func) == FN_QUERY)
						expected_q.push_back(mk(EV_DONE, ST_OK, s, run_q[s], count_q[s], 1));
					else
						expected_q.push_back(mk(EV_DONE, ST_OK, s, 0, 0, 1));
				end
			end
		endcase
	endtask

	task automatic send_item(func_t f, logic [4:0] s, logic [31:0] iv, logic p,
			logic [31:0] el);
		cmd_t c;
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c.func = f;
		c.slot = s;
		c.interval = iv;
		c.periodic = p;
		c.elapsed = el;
		push <= 1'b1;
		func <= f;
		slot <= s;
		interval <= iv;
		periodic <= p;
		elapsed <= el;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_timers(c);
		items_sent++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (NT + 10) @(posedge clk);
	endtask

	function automatic logic [4:0] live_slot();
		int k;
		for (k = 0; k < 4; k++) begin
			int s;
			s = $urandom_range(0, NT - 1);
			if (alloc_q[s]) return 5'(s);
		end
		return 5'($urandom_range(0, NT - 1));
	endfunction

	task automatic rand_item(bit busy_ticks);
		int pick;
		logic [31:0] iv;
		pick = $urandom_range(0, 99);
		iv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
		if (pick < 18)
			send_item(FN_CREATE, 5'($urandom), iv, 1'($urandom), $urandom);
		else if (pick < 38)
			send_item(FN_START, live_slot(), $urandom, 1'($urandom), $urandom);
		else if (pick < 45)
			send_item(FN_STOP, live_slot(), $urandom, 1'($urandom), $urandom);
		else if (pick < 52)
			send_item(FN_DELETE, live_slot(), $urandom, 1'($urandom), $urandom);
		else if (pick < 58)
			send_item(FN_SETIV, live_slot(), iv, 1'($urandom), $urandom);
		else if (pick < (busy_ticks ? 85 : 78))
			send_item(FN_TICK, 5'($urandom), $urandom,
				1'($urandom), ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 25));
		else if (pick < 97)
			send_item(FN_QUERY, live_slot(), $urandom, 1'($urandom), $urandom);
		else
			send_item(FN_NOP, 5'($urandom), $urandom, 1'($urandom), $urandom);
	endtask

	task automatic test_directed();
		int k;
		send_item(FN_QUERY, 5'd31, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
		send_item(FN_START, 5'd0, 0, 0, 0);
		send_item(FN_NOP, 5'h15, 32'hAAAA_AAAA, 1, 32'h5555_5555);
		send_item(FN_CREATE, 0, 32'hFFFF_FFFF, 0, 0);
		send_item(FN_CREATE, 0, 0, 1, 0);
		send_item(FN_CREATE, 0, 5, 1, 0);
		send_item(FN_START, 5'd0, 0, 0, 0);
		send_item(FN_START, 5'd1, 0, 0, 0);
		send_item(FN_START, 5'd2, 0, 0, 0);
		send_item(FN_QUERY, 5'd0, 0, 0, 0);
		send_item(FN_TICK, 0, 0, 0, 3);
		send_item(FN_START, 5'd2, 0, 0, 0);
		send_item(FN_SETIV, 5'd2, 9, 0, 0);
		send_item(FN_QUERY, 5'd2, 0, 0, 0);
		send_item(FN_TICK, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(FN_STOP, 5'd2, 0, 0, 0);
		send_item(FN_QUERY, 5'd2, 0, 0, 0);
		send_item(FN_DELETE, 5'd1, 0, 0, 0);
		send_item(FN_DELETE, 5'd1, 0, 0, 0);
		for (k = 0; k < NT + 1; k++)
			send_item(FN_CREATE, 0, k, k[0], 0);
		send_item(FN_TICK, 0, 0, 0, 1);
		drain_results();
	endtask

	task automatic test_full_tick();
		int k;
		for (k = 0; k < NT; k++)
			if (alloc_q[k]) send_item(FN_START, 5'(k), 0, 0, 0);
		send_item(FN_TICK, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(FN_TICK, 0, 0, 0, 0);
		for (k = 0; k < NT; k++)
			if (alloc_q[k]) send_item(FN_DELETE, 5'(k), 0, 0, 0);
		drain_results();
	endtask

	task automatic test_backpressure();
		int k;
		hold_pop = 1;
		for (k = 0; k < 12; k++) rand_item(1);
		hold_pop = 0;
		drain_results();
	endtask

	task automatic test_random();
		int k;
		for (k = 0; k < 140; k++) rand_item(0);
		drain_results();
		idle_on = 0;
		for (k = 0; k < 40; k++) rand_item(1);
		drain_results();
	endtask

	initial begin
		int hold;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pop) begin
				pop <= 1'b0;
				hold = 0;
				while (hold < 300) begin
					@(posedge clk);
					hold++;
				end
				pop <= 1'b1;
				while (hold_pop) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (event_res == EV_EXPIRED) expiries_seen++;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: event_res %0d slot_out %0d",
					event_res, slot_out);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (event_res !== e.event_res) begin
					$error("event_res expected %0d actual %0d", e.event_res, event_res);
					errors++;
				end
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					errors++;
				end
				if (slot_out !== e.slot_out) begin
					$error("slot_out expected %0d actual %0d", e.slot_out, slot_out);
					errors++;
				end
				if (is_active !== e.is_active) begin
					$error("is_active expected %0d actual %0d", e.is_active, is_active);
					errors++;
				end
				if (remaining_out !== e.remaining_out) begin
					$error("remaining_out expected %0d actual %0d", e.remaining_out,
						remaining_out);
					errors++;
				end
				if (last !== e.last) begin
					$error("last expected %0d actual %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("timer_bank_with_slot_pool_unit verification failed");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		push = 1'b0;
		func = '0;
		slot = '0;
		interval = '0;
		periodic = 1'b0;
		elapsed = '0;
		for (k = 0; k < NT; k++) begin
			run_q[k] = 0;
			alloc_q[k] = 0;
			auto_q[k] = 0;
			reload_q[k] = 0;
			count_q[k] = 0;
			free_stk[k] = 5'(NT - 1 - k);
		end
		free_n = NT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_tick();
		test_backpressure();
		test_random();
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			errors++;
		end
		$display("Sent %0d commands; checked %0d results including %0d expiries.",
			items_sent, results_seen, expiries_seen);
		$display("Covered pool exhaustion, unallocated slots, periodic reloads and stalls.");
		if (errors == 0)
			$display("timer_bank_with_slot_pool_unit verification clean");
		else
			$display("timer_bank_with_slot_pool_unit verification failed");
		$finish;
	end
endmodule
